// ===== rtl/rtbrs_pkg.sv =====
// shared request codes, status codes, chain token type and prefix helper
package rtbrs_pkg;

    // default number of route slots
    localparam int ROUTE_SLOTS_DEF = 16;

    // slot index and rank width, covers the full slot range up to 256
    localparam int SLOT_W = 8;

    // request codes
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_UPDATE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
    localparam logic [1:0] ST_NO_ROUTE   = 2'd3;

    // token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic              live;       // token present in this stage
        logic [2:0]        req;        // request code
        logic              close_up;   // second remove pass: close rank gap
        logic [31:0]       gw;         // router address for add or update
        logic [7:0]        ns;         // neighbor state for add or update
        logic [31:0]       dest;       // lookup destination
        logic              given;      // destination present
        logic [SLOT_W-1:0] handle;     // remove target slot
        logic [SLOT_W-1:0] rank;       // add: new rank, remove: removed rank
        logic              hit;        // placed, found, or route chosen
        logic [SLOT_W-1:0] slot;       // slot of placed or chosen route
        logic [7:0]        best_ns;
        logic [5:0]        best_len;
        logic [SLOT_W-1:0] best_rank;
        logic [31:0]       best_gw;
    } token_t;

    // leading equal bits of two addresses from bit 31 down
    function automatic logic [5:0] prefix_len(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        logic [5:0]  n;
        diff = a ^ b;
        n    = 6'd32;
        for (int k = 0; k < 32; k++)
        begin
            if (diff[k])
            begin
                n = 6'(31 - k);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/rtbrs_cell.sv =====
// one route slot of the chain: holds a route and works on the passing token
module rtbrs_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rtbrs_pkg::SLOT_W-1:0]     slot_idx,
    input  rtbrs_pkg::token_t                tok_in,
    output rtbrs_pkg::token_t                tok_out
);
    import rtbrs_pkg::*;

    logic              valid_reg, valid_next;
    logic [31:0]       gw_reg, gw_next;
    logic [7:0]        ns_reg, ns_next;
    logic [SLOT_W-1:0] rank_reg, rank_next;
    token_t            tok_reg, tok_next;
    logic [5:0]        len;
    logic              better;

    // prefix length against this slot's router
    assign len = tok_in.given ? prefix_len(tok_in.dest, gw_reg) : 6'd0;

    // lookup ordering: state, then prefix, then earlier insertion
    always_comb
    begin
        if (!tok_in.hit)
        begin
            better = 1'b1;
        end
        else if (ns_reg != tok_in.best_ns)
        begin
            better = ns_reg > tok_in.best_ns;
        end
        else if (len != tok_in.best_len)
        begin
            better = len > tok_in.best_len;
        end
        else
        begin
            better = rank_reg < tok_in.best_rank;
        end
    end

    // slot update and token hand-off
    always_comb
    begin
        valid_next = valid_reg;
        gw_next    = gw_reg;
        ns_next    = ns_reg;
        rank_next  = rank_reg;
        tok_next   = tok_in;
        if (tok_in.live)
        begin
            case (tok_in.req)
                REQ_ADD:
                begin
                    if (!tok_in.hit && !valid_reg)
                    begin
                        valid_next    = 1'b1;
                        gw_next       = tok_in.gw;
                        ns_next       = tok_in.ns;
                        rank_next     = tok_in.rank;
                        tok_next.hit  = 1'b1;
                        tok_next.slot = slot_idx;
                    end
                end
                REQ_REMOVE:
                begin
                    if (!tok_in.close_up)
                    begin
                        if (valid_reg && slot_idx == tok_in.handle)
                        begin
                            valid_next    = 1'b0;
                            tok_next.hit  = 1'b1;
                            tok_next.rank = rank_reg;
                        end
                    end
                    else if (valid_reg && rank_reg > tok_in.rank)
                    begin
                        rank_next = rank_reg - 1'b1;
                    end
                end
                REQ_LOOKUP:
                begin
                    if (valid_reg && better)
                    begin
                        tok_next.hit       = 1'b1;
                        tok_next.slot      = slot_idx;
                        tok_next.best_ns   = ns_reg;
                        tok_next.best_len  = len;
                        tok_next.best_rank = rank_reg;
                        tok_next.best_gw   = gw_reg;
                    end
                end
                REQ_UPDATE:
                begin
                    if (valid_reg && gw_reg == tok_in.gw)
                    begin
                        ns_next = tok_in.ns;
                    end
                end
                REQ_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state and token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // route payload
    always_ff @(posedge clk)
    begin
        gw_reg   <= gw_next;
        ns_reg   <= ns_next;
        rank_reg <= rank_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/route_table_best_router_select_top.sv =====
// route table with best-router selection: request launch, cell chain, response
//
// Routes live in a chain of ROUTE_SLOTS cells, one route per cell. Every request
// enters the head of the chain as a token and moves one cell per clock; add,
// lookup, update, clear and unused codes pass the chain once, then the response
// goes through done_reg to the output register; a remove of a valid handle walks
// the chain twice (find the slot, then close the rank gap). One request is in the
// table at a time, so req_ready is low from acceptance until the response is moved
// to the output register; a waiting response does not block the next request.
module route_table_best_router_select_top #(
    parameter int ROUTE_SLOTS = rtbrs_pkg::ROUTE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [3:0]  entry_handle,
    input  logic [31:0] gateway_addr,
    input  logic [7:0]  neighbor_state,
    input  logic [31:0] dest_addr,
    input  logic        dest_given,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [3:0]  result_handle,
    output logic [31:0] chosen_gateway,
    output logic [5:0]  match_length,
    output logic [4:0]  route_count
);
    import rtbrs_pkg::*;

    localparam int CNT_W = $clog2(ROUTE_SLOTS + 1);

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  handle;
        logic [31:0] gw;
        logic [5:0]  len;
        logic [4:0]  count;
    } rsp_t;

    token_t           tok [0:ROUTE_SLOTS];
    token_t           tail;
    logic             accept;
    logic             tail_first_rm;
    logic             tail_final;
    logic             move_out;
    logic             busy_reg, busy_next;
    logic             done_vld_reg, done_vld_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    rsp_t             done_reg, done_next;
    rsp_t             out_reg;

    assign accept    = req_valid && req_ready;
    assign req_ready = !busy_reg;
    assign tail      = tok[ROUTE_SLOTS];

    // a found remove goes around once more to close the rank gap
    assign tail_first_rm = tail.live && tail.req == REQ_REMOVE && !tail.close_up && tail.hit;
    assign tail_final    = tail.live && !tail_first_rm;
    assign move_out      = done_vld_reg && (!rsp_valid_reg || rsp_ready);

    // token entering the head of the chain
    always_comb
    begin
        tok[0] = '0;
        if (accept)
        begin
            tok[0].live   = 1'b1;
            tok[0].req    = req_type;
            tok[0].gw     = gateway_addr;
            tok[0].ns     = neighbor_state;
            tok[0].dest   = dest_addr;
            tok[0].given  = dest_given;
            tok[0].handle = SLOT_W'(entry_handle);
            tok[0].rank   = SLOT_W'(count_reg);
        end
        else if (tail_first_rm)
        begin
            tok[0]          = tail;
            tok[0].close_up = 1'b1;
        end
    end

    // chain of route cells
    for (genvar i = 0; i < ROUTE_SLOTS; i++)
    begin : g_cell
        rtbrs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_idx (SLOT_W'(i)),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    // route count follows the request leaving the chain
    always_comb
    begin
        count_next = count_reg;
        if (tail.live)
        begin
            case (tail.req)
                REQ_ADD:
                begin
                    if (tail.hit)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    if (tail_first_rm)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // response built from the finished token
    always_comb
    begin
        done_next        = '0;
        done_next.count  = 5'(count_next);
        case (tail.req)
            REQ_ADD:
            begin
                done_next.status = tail.hit ? ST_OK : ST_FULL;
                if (tail.hit)
                begin
                    done_next.handle = tail.slot[3:0];
                end
            end
            REQ_REMOVE:
            begin
                done_next.status = tail.close_up ? ST_OK : ST_BAD_HANDLE;
            end
            REQ_LOOKUP:
            begin
                done_next.status = tail.hit ? ST_OK : ST_NO_ROUTE;
                if (tail.hit)
                begin
                    done_next.handle = tail.slot[3:0];
                    done_next.gw     = tail.best_gw;
                    done_next.len    = tail.best_len;
                end
            end
            default:
            begin
                done_next.status = ST_OK;
            end
        endcase
    end

    // handshake control
    always_comb
    begin
        busy_next      = busy_reg;
        done_vld_next  = done_vld_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (move_out)
        begin
            rsp_valid_next = 1'b1;
            done_vld_next  = 1'b0;
            busy_next      = 1'b0;
        end
        if (tail_final)
        begin
            done_vld_next = 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_vld_reg  <= done_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (tail_final)
        begin
            done_reg <= done_next;
        end
        if (move_out)
        begin
            out_reg <= done_reg;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = out_reg.status;
    assign result_handle  = out_reg.handle;
    assign chosen_gateway = out_reg.gw;
    assign match_length   = out_reg.len;
    assign route_count    = out_reg.count;

endmodule

// ===== rtl/rtbrs_chk.sv =====
// port checker for the route table, bound to the top level
module rtbrs_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [3:0]  result_handle,
    input logic [31:0] chosen_gateway,
    input logic [5:0]  match_length,
    input logic [4:0]  route_count
);
    import rtbrs_pkg::*;

    // one request at a time in the table
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in the table");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
        $stable(result_handle) && $stable(chosen_gateway) && $stable(route_count))
        else $error("response changed while stalled");

    // a full table answers with empty route fields
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |->
        result_handle == 4'd0 && chosen_gateway == 32'd0 && match_length == 6'd0)
        else $error("table full response carries route data");

    // no route only on an empty table, prefix never beyond 32 bits
    a_no_route_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status != ST_NO_ROUTE || route_count == 5'd0) &&
        match_length <= 6'd32)
        else $error("lookup miss with routes present or bad prefix length");

endmodule

bind route_table_best_router_select_top rtbrs_chk u_rtbrs_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .result_handle  (result_handle),
    .chosen_gateway (chosen_gateway),
    .match_length   (match_length),
    .route_count    (route_count)
);

// ===== bench/route_answer_checker.sv =====
// route table checker: predicts every answer and compares it on the response channel
module route_answer_checker
    import rtbrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [3:0]  entry_handle,
    input  logic [31:0] gateway_addr,
    input  logic [7:0]  neighbor_state,
    input  logic [31:0] dest_addr,
    input  logic        dest_given,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  status,
    input  logic [3:0]  result_handle,
    input  logic [31:0] chosen_gateway,
    input  logic [5:0]  match_length,
    input  logic [4:0]  route_count,
    output int          mismatches,
    output int          awaiting_count,
    output int          answers_checked,
    output int          full_count,
    output int          bad_handle_count,
    output int          no_route_count
);

    localparam int SLOTS = ROUTE_SLOTS_DEF;

    typedef struct packed {
        logic [1:0]  st;
        logic [3:0]  hnd;
        logic [31:0] gw;
        logic [5:0]  len;
        logic [4:0]  cnt;
    } answer_t;

    // shadow copy of the route table
    logic        route_used [SLOTS];
    logic [31:0] route_gw   [SLOTS];
    logic [7:0]  route_ns   [SLOTS];
    logic [3:0]  route_rank [SLOTS];
    logic [4:0]  route_total;

    // answers predicted but not yet seen, oldest first
    answer_t awaiting_answers[$];

    // leading bits on which two addresses agree, msb first
    function automatic logic [5:0] common_bits(input logic [31:0] a, input logic [31:0] b);
        logic [5:0] n;
        logic       stop;
        n    = '0;
        stop = 1'b0;
        for (int k = 31; k >= 0; k--)
        begin
            if (!stop && a[k] == b[k])
                n++;
            else
                stop = 1'b1;
        end
        return n;
    endfunction

    // applies one request to the shadow table and returns its answer
    function automatic answer_t predict_answer(input logic [2:0] op, input logic [3:0] hnd,
                                               input logic [31:0] gw, input logic [7:0] ns,
                                               input logic [31:0] dest, input logic given);
        answer_t    ans;
        logic       placed;
        logic       found;
        logic       better;
        logic [3:0] gone;
        logic [3:0] best;
        logic [5:0] len;
        logic [5:0] best_len;
        ans      = '0;
        placed   = 1'b0;
        found    = 1'b0;
        best     = '0;
        best_len = '0;
        case (op)
            REQ_ADD:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!placed && !route_used[i])
                    begin
                        route_used[i] = 1'b1;
                        route_gw[i]   = gw;
                        route_ns[i]   = ns;
                        route_rank[i] = route_total[3:0];
                        route_total++;
                        ans.hnd = 4'(i);
                        placed  = 1'b1;
                    end
                end
                if (!placed)
                    ans.st = ST_FULL;
            end
            REQ_REMOVE:
            begin
                if (!route_used[hnd])
                begin
                    ans.st = ST_BAD_HANDLE;
                end
                else
                begin
                    // close the rank gap left by the removed route
                    gone = route_rank[hnd];
                    route_used[hnd] = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (route_used[i] && route_rank[i] > gone)
                            route_rank[i]--;
                    end
                    route_total--;
                end
            end
            REQ_LOOKUP:
            begin
                // best state, then longest prefix, then earliest insertion
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (route_used[i])
                    begin
                        len = given ? common_bits(dest, route_gw[i]) : 6'd0;
                        if (!found)
                            better = 1'b1;
                        else if (route_ns[i] != route_ns[best])
                            better = route_ns[i] > route_ns[best];
                        else if (len != best_len)
                            better = len > best_len;
                        else
                            better = route_rank[i] < route_rank[best];
                        if (better)
                        begin
                            found    = 1'b1;
                            best     = 4'(i);
                            best_len = len;
                        end
                    end
                end
                if (found)
                begin
                    ans.hnd = best;
                    ans.gw  = route_gw[best];
                    ans.len = best_len;
                end
                else
                begin
                    ans.st = ST_NO_ROUTE;
                end
            end
            REQ_UPDATE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (route_used[i] && route_gw[i] == gw)
                        route_ns[i] = ns;
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    route_used[i] = 1'b0;
                route_total = '0;
            end
            default:
            begin
            end
        endcase
        ans.cnt = route_total;
        return ans;
    endfunction

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at answer %0d: %s got %0h expected %0h",
                 answers_checked, what, got, want);
    endtask

    // compare answers first, then predict the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                route_used[i] = 1'b0;
            route_total = '0;
            awaiting_answers.delete();
            awaiting_count   = 0;
            mismatches       = 0;
            answers_checked  = 0;
            full_count       = 0;
            bad_handle_count = 0;
            no_route_count   = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaiting_answers.size() == 0)
                begin
                    report_mismatch("answer with no request pending", {30'd0, status}, 32'd0);
                end
                else
                begin
                    want = awaiting_answers.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", {30'd0, status}, {30'd0, want.st});
                    if (result_handle !== want.hnd)
                        report_mismatch("result_handle", {28'd0, result_handle},
                                        {28'd0, want.hnd});
                    if (chosen_gateway !== want.gw)
                        report_mismatch("chosen_gateway", chosen_gateway, want.gw);
                    if (match_length !== want.len)
                        report_mismatch("match_length", {26'd0, match_length},
                                        {26'd0, want.len});
                    if (route_count !== want.cnt)
                        report_mismatch("route_count", {27'd0, route_count}, {27'd0, want.cnt});
                    case (want.st)
                        ST_FULL:       full_count++;
                        ST_BAD_HANDLE: bad_handle_count++;
                        ST_NO_ROUTE:   no_route_count++;
                        default:
                        begin
                        end
                    endcase
                end
                answers_checked++;
            end
            if (req_valid && req_ready)
                awaiting_answers.push_back(predict_answer(req_type, entry_handle, gateway_addr,
                                                          neighbor_state, dest_addr, dest_given));
            awaiting_count = awaiting_answers.size();
        end
    end

endmodule

// ===== bench/tb_route_table_best_router_select_top.sv =====
// route table testbench top: request stimulus, response pacing, watchdog and verdict
module tb_route_table_best_router_select_top;

    import rtbrs_pkg::*;

    // request codes the block answers without acting
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1625;
    localparam int PHASE_ITEMS  = 550;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [2:0]  req_type;
    logic [3:0]  entry_handle;
    logic [31:0] gateway_addr;
    logic [7:0]  neighbor_state;
    logic [31:0] dest_addr;
    logic        dest_given;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [1:0]  status;
    logic [3:0]  result_handle;
    logic [31:0] chosen_gateway;
    logic [5:0]  match_length;
    logic [4:0]  route_count;

    int mismatches;
    int awaiting_count;
    int answers_checked;
    int full_count;
    int bad_handle_count;
    int no_route_count;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_rsp;
    int          requests_sent;
    int          quiet_cycles;
    logic [31:0] gw_pool [8];

    route_table_best_router_select_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .entry_handle   (entry_handle),
        .gateway_addr   (gateway_addr),
        .neighbor_state (neighbor_state),
        .dest_addr      (dest_addr),
        .dest_given     (dest_given),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .result_handle  (result_handle),
        .chosen_gateway (chosen_gateway),
        .match_length   (match_length),
        .route_count    (route_count)
    );

    route_answer_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req_type         (req_type),
        .entry_handle     (entry_handle),
        .gateway_addr     (gateway_addr),
        .neighbor_state   (neighbor_state),
        .dest_addr        (dest_addr),
        .dest_given       (dest_given),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .status           (status),
        .result_handle    (result_handle),
        .chosen_gateway   (chosen_gateway),
        .match_length     (match_length),
        .route_count      (route_count),
        .mismatches       (mismatches),
        .awaiting_count   (awaiting_count),
        .answers_checked  (answers_checked),
        .full_count       (full_count),
        .bad_handle_count (bad_handle_count),
        .no_route_count   (no_route_count)
    );

    // clock, period 4
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // response pacing, with an optional long hold-off
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                rsp_ready <= 1'b0;
            end
            else if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("watchdog: %0d cycles without a handshake", QUIET_LIMIT);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // offer one request, with random idle cycles ahead of it; returns at the next falling edge
    task automatic send_req(input logic [2:0] op, input logic [3:0] hnd, input logic [31:0] gw,
                            input logic [7:0] ns, input logic [31:0] dest, input logic given);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid      <= 1'b1;
        req_type       <= op;
        entry_handle   <= hnd;
        gateway_addr   <= gw;
        neighbor_state <= ns;
        dest_addr      <= dest;
        dest_given     <= given;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // stop offering until every answer is back
    task automatic pause_until_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (awaiting_count != 0)
            @(negedge clk);
    endtask

    // router address, mostly from a small pool so updates and ties hit
    function automatic logic [31:0] pick_gateway();
        if ($urandom_range(99) < 70)
            return gw_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // neighbor state, biased toward a few values so ties are common
    function automatic logic [7:0] pick_state();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 8'($urandom_range(3));
        if (r < 70)
            return 8'hff;
        if (r < 80)
            return 8'h80;
        return 8'($urandom);
    endfunction

    // destination near a pool address so prefix lengths spread out
    function automatic logic [31:0] pick_dest();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return gw_pool[$urandom_range(7)];
        if (r < 70)
            return gw_pool[$urandom_range(7)] ^ (32'($urandom) >> $urandom_range(31));
        return $urandom;
    endfunction

    // one random request or a burst of adds that fills the table
    task automatic send_random();
        int          r;
        logic [2:0]  op;
        r = $urandom_range(99);
        if (r < 6)
        begin
            repeat (17)
                send_req(REQ_ADD, 4'($urandom), pick_gateway(), pick_state(), $urandom,
                         1'($urandom));
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 34)
                op = REQ_ADD;
            else if (r < 54)
                op = REQ_REMOVE;
            else if (r < 84)
                op = REQ_LOOKUP;
            else if (r < 92)
                op = REQ_UPDATE;
            else if (r < 94)
                op = REQ_CLEAR;
            else if (r < 97)
                op = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            else
                op = 3'($urandom);
            if (r >= 97)
                send_req(op, 4'($urandom), $urandom, 8'($urandom), $urandom, 1'($urandom));
            else
                send_req(op, 4'($urandom), pick_gateway(), pick_state(), pick_dest(),
                         ($urandom_range(99) < 80));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int phase;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_type       = REQ_LOOKUP;
        entry_handle   = '0;
        gateway_addr   = '0;
        neighbor_state = '0;
        dest_addr      = '0;
        dest_given     = 1'b0;
        hold_rsp       = 1'b0;
        requests_sent  = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 17;
        recv_idle_pct  = 82;
        phase          = 0;

        // pool with shared upper bits so prefix ties happen
        gw_pool[0] = 32'h0000_0000;
        gw_pool[1] = 32'hffff_ffff;
        gw_pool[2] = $urandom;
        for (int i = 3; i < 8; i++)
            gw_pool[i] = (gw_pool[2] & ~(32'hffff_ffff >> (4 * i))) |
                         (32'($urandom) >> (4 * i));

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, extremes, ties, rank close-up, unused codes, clear
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'h1234_5678, 1'b1);
        send_req(REQ_REMOVE, 4'd0, 32'd0, 8'd0, 32'd0, 1'b0);
        send_req(REQ_ADD, 4'd0, 32'h0000_0000, 8'h00, 32'd0, 1'b0);
        send_req(REQ_ADD, 4'd0, 32'hffff_ffff, 8'hff, 32'd0, 1'b0);
        send_req(REQ_ADD, 4'd0, 32'hc0a8_0001, 8'hff, 32'd0, 1'b0);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'hffff_ffff, 1'b1);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'hc0a8_0001, 1'b0);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'hc0a8_0001, 1'b1);
        send_req(REQ_UPDATE, 4'd0, 32'h0000_0000, 8'hff, 32'd0, 1'b0);
        send_req(REQ_UPDATE, 4'd0, 32'h1234_5678, 8'h01, 32'd0, 1'b0);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'h8000_0000, 1'b1);
        send_req(REQ_REMOVE, 4'd1, 32'd0, 8'd0, 32'd0, 1'b0);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'h0000_0000, 1'b1);
        send_req(REQ_ADD, 4'd0, 32'hffff_ffff, 8'hff, 32'd0, 1'b0);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'hffff_ffff, 1'b0);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'h7fff_ffff, 1'b1);
        send_req(REQ_UNUSED_LO, 4'd15, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1'b1);
        send_req(3'd6, 4'd0, 32'd0, 8'd0, 32'd0, 1'b0);
        send_req(REQ_UNUSED_HI, 4'd5, 32'h5555_aaaa, 8'h55, 32'haaaa_5555, 1'b0);
        send_req(REQ_REMOVE, 4'd15, 32'd0, 8'd0, 32'd0, 1'b0);
        send_req(REQ_CLEAR, 4'd0, 32'd0, 8'd0, 32'd0, 1'b0);
        send_req(REQ_LOOKUP, 4'd0, 32'd0, 8'd0, 32'hffff_ffff, 1'b1);

        // random part in three pacing phases
        while (requests_sent < RANDOM_ITEMS + 22)
        begin
            if (phase == 0 && requests_sent >= PHASE_ITEMS)
            begin
                pause_until_drained();
                send_idle_pct = 82;
                recv_idle_pct = 17;
                phase         = 1;
            end
            else if (phase == 1 && requests_sent >= 2 * PHASE_ITEMS)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_rsp      = 1'b1;
                phase         = 2;
            end
            send_random();
        end

        // drain and verdict
        req_valid <= 1'b0;
        @(negedge clk);
        while (awaiting_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d requests and %0d answers over three pacing phases",
                 requests_sent, answers_checked);
        $display("answers seen: %0d table full, %0d bad handle, %0d no route",
                 full_count, bad_handle_count, no_route_count);
        if (mismatches == 0 && awaiting_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rtbrs_pkg.sv
rtl/rtbrs_cell.sv
rtl/route_table_best_router_select_top.sv
rtl/rtbrs_chk.sv
bench/route_answer_checker.sv
bench/tb_route_table_best_router_select_top.sv
